// ===== sv/bta_pkg.sv =====
// Package for the balanced ternary arithmetic unit.
// Holds opcodes, trit codes, word widths and the structs shared by the step unit and the top level.
// Depends on nothing.
package bta_pkg;

    // Word geometry: 2-bit trit codes packed into a 32-bit word.
    localparam int WORD_W         = 32;
    localparam int MAX_WORD_TRITS = WORD_W / 2;
    localparam int TRIT_COUNT_DEF = 16;

    // Widths of the conversion datapath.
    localparam int BIN_W  = 26;
    localparam int POW_W  = 25;
    localparam int QUOT_W = 31;

    // Reciprocal of three for a 32-bit dividend, scaled by 2^33.
    localparam logic [WORD_W-1:0] RECIP3 = 32'hAAAA_AAAB;

    // Opcodes.
    localparam logic [2:0] OP_ADD      = 3'd0;
    localparam logic [2:0] OP_NEG      = 3'd1;
    localparam logic [2:0] OP_SHIFT    = 3'd2;
    localparam logic [2:0] OP_FROM_BIN = 3'd3;
    localparam logic [2:0] OP_TO_BIN   = 3'd4;

    // Trit codes. A valid code is the two's complement value of its trit.
    localparam logic [1:0] TRIT_ZERO = 2'b00;
    localparam logic [1:0] TRIT_POS  = 2'b01;
    localparam logic [1:0] TRIT_BAD  = 2'b10;
    localparam logic [1:0] TRIT_NEG  = 2'b11;

    // Running state carried from one trit step to the next.
    typedef struct packed {
        logic signed [1:0]       carry;
        logic signed [BIN_W-1:0] acc;
        logic [POW_W-1:0]        pow;
        logic [WORD_W-1:0]       u;
    } step_state_t;

    // Per-step control from the sequencer.
    typedef struct packed {
        logic [2:0] op;
        logic       sh_active;
        logic       neg;
    } step_ctl_t;

    // Result of one trit step.
    typedef struct packed {
        logic [1:0]  code;
        step_state_t st;
    } step_res_t;

    // Value of a trit code; the unused code reads as zero.
    function automatic logic signed [1:0] trit_value(input logic [1:0] code);
        trit_value = (code == TRIT_BAD) ? 2'sd0 : signed'(code);
    endfunction

endpackage

// ===== sv/bta_if.sv =====
// Channel interfaces of the balanced ternary arithmetic unit.
// bta_req_if carries an operation, bta_rsp_if carries its result.
// Depends on bta_pkg for the word widths.
interface bta_req_if;
    logic                              valid;
    logic                              ready;
    logic [2:0]                        opcode;
    logic [bta_pkg::WORD_W-1:0]        operand_a;
    logic [bta_pkg::WORD_W-1:0]        operand_b;
    logic [4:0]                        shift_amount;
    logic signed [bta_pkg::WORD_W-1:0] binary_value;

    modport source (output valid, opcode, operand_a, operand_b, shift_amount, binary_value,
                    input ready);
    modport sink   (input valid, opcode, operand_a, operand_b, shift_amount, binary_value,
                    output ready);
endinterface

interface bta_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [bta_pkg::WORD_W-1:0]       trit_result;
    logic signed [bta_pkg::BIN_W-1:0] binary_result;
    logic                             overflow;
    logic                             invalid_trit;

    modport source (output valid, trit_result, binary_result, overflow, invalid_trit,
                    input ready);
    modport sink   (input valid, trit_result, binary_result, overflow, invalid_trit,
                    output ready);
endinterface

// ===== sv/bta_recip_mul.sv =====
// Registered reciprocal multiplier that gives floor(u / 3) for a 32-bit u.
// Used by the binary to ternary conversion, one quotient per digit.
// Depends on bta_pkg.
module bta_recip_mul
(
    input  logic                         clk,
    input  logic                         en,
    input  logic [bta_pkg::WORD_W-1:0]   u,
    output logic [bta_pkg::QUOT_W-1:0]   q
);

    logic [2*bta_pkg::WORD_W-1:0] prod;
    logic [bta_pkg::QUOT_W-1:0]   q_reg;

    // One 32 by 32 product; the quotient is its top 31 bits.
    assign prod = {{bta_pkg::WORD_W{1'b0}}, u} *
                  {{bta_pkg::WORD_W{1'b0}}, bta_pkg::RECIP3};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= prod[2*bta_pkg::WORD_W-1 -: bta_pkg::QUOT_W];
        end
    end

    assign q = q_reg;

endmodule

// ===== sv/bta_step.sv =====
// Shared trit step unit: processes one trit position for every operation.
// Add with carry, negate, shift select, one digit of binary to ternary, one term of ternary to binary.
// Depends on bta_pkg.
module bta_step
(
    input  bta_pkg::step_ctl_t          ctl,
    input  logic [1:0]                  code_a,
    input  logic [1:0]                  code_b,
    input  bta_pkg::step_state_t        st,
    input  logic [bta_pkg::QUOT_W-1:0]  q,
    output bta_pkg::step_res_t          res
);

    logic signed [2:0]                ta;
    logic signed [2:0]                tb;
    logic signed [2:0]                sum;
    logic [1:0]                       rem;
    logic signed [1:0]                digit;
    logic signed [bta_pkg::BIN_W-1:0] pow_s;

    assign ta    = 3'(bta_pkg::trit_value(code_a));
    assign tb    = 3'(bta_pkg::trit_value(code_b));
    assign sum   = ta + tb + 3'(st.carry);
    assign pow_s = signed'({1'b0, st.pow});

    // Remainder of u by three, from the low bits of u - 3q.
    assign rem   = st.u[1:0] - {q[0], 1'b0} - q[1:0];
    assign digit = (rem == 2'd2) ? -2'sd1 : signed'(rem);

    always_comb
    begin
        res.code = bta_pkg::TRIT_ZERO;
        res.st   = st;
        case (ctl.op)
            bta_pkg::OP_ADD:
            begin
                // Balanced digit with a carry of -1, 0 or +1.
                if (sum > 3'sd1)
                begin
                    res.code     = 2'(sum - 3'sd3);
                    res.st.carry = 2'sd1;
                end
                else if (sum < -3'sd1)
                begin
                    res.code     = 2'(sum + 3'sd3);
                    res.st.carry = -2'sd1;
                end
                else
                begin
                    res.code     = 2'(sum);
                    res.st.carry = 2'sd0;
                end
            end
            bta_pkg::OP_NEG:
            begin
                res.code = 2'(-ta);
            end
            bta_pkg::OP_SHIFT:
            begin
                res.code = ctl.sh_active ? 2'(ta) : bta_pkg::TRIT_ZERO;
            end
            bta_pkg::OP_FROM_BIN:
            begin
                // Digit of the magnitude; a negative input flips every digit.
                res.code = ctl.neg ? 2'(-digit) : 2'(digit);
                res.st.u = {1'b0, q} + bta_pkg::WORD_W'(rem == 2'd2);
            end
            bta_pkg::OP_TO_BIN:
            begin
                // Accumulate trit times the current power of three.
                if (ta > 3'sd0)
                begin
                    res.st.acc = st.acc + pow_s;
                end
                else if (ta < 3'sd0)
                begin
                    res.st.acc = st.acc - pow_s;
                end
                res.st.pow = st.pow + {st.pow[bta_pkg::POW_W-2:0], 1'b0};
            end
            default:
            begin
                res.code = bta_pkg::TRIT_ZERO;
            end
        endcase
    end

endmodule

// ===== sv/balanced_ternary_alu.sv =====
// Top level of the balanced ternary arithmetic unit: sequencer, operand and result registers.
// Instantiates bta_step and bta_recip_mul; uses bta_pkg and the interfaces in bta_if.
// Depends on bta_pkg, bta_if, bta_step and bta_recip_mul.

// A request is processed least significant trit first by a single shared step unit, one
// trit per cycle for add, negate, shift and ternary to binary; a finishing state then hands
// the result to the output register once it is free. Binary to ternary takes each digit
// through the registered divide-by-three multiplier and then the step unit. The input is
// ready only while the unit is idle, so a new request is not taken before the last one is
// finished; a finished result waits in the output register and the next request is taken
// meanwhile. Trits at position 16 and above do not fit the 32-bit word: they read as zero
// and are dropped from the result.
module balanced_ternary_alu
#(
    parameter int TRIT_COUNT = bta_pkg::TRIT_COUNT_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    bta_req_if.sink    req,
    bta_rsp_if.source  rsp
);

    localparam int WORD_TRITS = (TRIT_COUNT < bta_pkg::MAX_WORD_TRITS) ?
                                TRIT_COUNT : bta_pkg::MAX_WORD_TRITS;
    localparam int STEP_W     = (TRIT_COUNT > 1) ? $clog2(TRIT_COUNT) : 1;
    localparam int CMP_W      = 6;
    localparam int TOP_LSB    = 2 * WORD_TRITS - 2;

    typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_STEP, ST_DONE} state_t;

    state_t                              state_reg, state_next;
    logic [STEP_W-1:0]                   step_reg, step_next;
    logic                                out_valid_reg, out_valid_next;
    logic [bta_pkg::WORD_W-1:0]          trit_result_reg, trit_result_next;
    logic signed [bta_pkg::BIN_W-1:0]    binary_result_reg, binary_result_next;
    logic                                overflow_reg, overflow_next;
    logic                                invalid_reg, invalid_next;

    logic [2:0]                          op_reg, op_next;
    logic [4:0]                          sh_reg, sh_next;
    logic                                neg_reg, neg_next;
    logic [bta_pkg::WORD_W-1:0]          a_reg, a_next;
    logic [bta_pkg::WORD_W-1:0]          b_reg, b_next;
    logic [bta_pkg::WORD_W-1:0]          res_reg, res_next;
    logic                                bad_reg, bad_next;
    bta_pkg::step_state_t                st_reg, st_next;

    logic                                accept;
    logic                                bad_in;
    logic                                chk_a;
    logic                                chk_b;
    logic                                sh_active;
    logic                                in_word;
    logic                                last_step;
    logic                                ovf_final;
    logic [bta_pkg::QUOT_W-1:0]          q;
    bta_pkg::step_ctl_t                  ctl;
    bta_pkg::step_res_t                  step_res;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;

    assign rsp.valid         = out_valid_reg;
    assign rsp.trit_result   = trit_result_reg;
    assign rsp.binary_result = binary_result_reg;
    assign rsp.overflow      = overflow_reg;
    assign rsp.invalid_trit  = invalid_reg;

    // Step position relative to the shift distance and the word size.
    assign sh_active = CMP_W'(step_reg) >= CMP_W'(sh_reg);
    assign in_word   = CMP_W'(step_reg) < CMP_W'(WORD_TRITS);
    assign last_step = step_reg == STEP_W'(TRIT_COUNT - 1);

    assign ctl.op        = op_reg;
    assign ctl.sh_active = sh_active;
    assign ctl.neg       = neg_reg;

    bta_step u_step
    (
        .ctl    (ctl),
        .code_a (a_reg[1:0]),
        .code_b (b_reg[1:0]),
        .st     (st_reg),
        .q      (q),
        .res    (step_res)
    );

    bta_recip_mul u_mul
    (
        .clk (clk),
        .en  (state_reg == ST_MUL),
        .u   (st_reg.u),
        .q   (q)
    );

    // Unused trit codes among the operand trits that the operation reads.
    always_comb
    begin
        chk_a = 1'b0;
        chk_b = 1'b0;
        case (req.opcode) inside
            bta_pkg::OP_ADD:
            begin
                chk_a = 1'b1;
                chk_b = 1'b1;
            end
            bta_pkg::OP_NEG, bta_pkg::OP_SHIFT, bta_pkg::OP_TO_BIN:
            begin
                chk_a = 1'b1;
            end
            default:
            begin
                chk_a = 1'b0;
            end
        endcase
        bad_in = 1'b0;
        for (int i = 0; i < WORD_TRITS; i++)
        begin
            if (chk_a && (req.operand_a[2*i +: 2] == bta_pkg::TRIT_BAD))
            begin
                bad_in = 1'b1;
            end
            if (chk_b && (req.operand_b[2*i +: 2] == bta_pkg::TRIT_BAD))
            begin
                bad_in = 1'b1;
            end
        end
    end

    // Overflow of a finished operation.
    always_comb
    begin
        case (op_reg)
            bta_pkg::OP_ADD:      ovf_final = (st_reg.carry != 2'sd0);
            bta_pkg::OP_FROM_BIN: ovf_final = (st_reg.u != '0);
            default:              ovf_final = 1'b0;
        endcase
    end

    // Sequencer and datapath next-state logic.
    always_comb
    begin
        state_next         = state_reg;
        step_next          = step_reg;
        out_valid_next     = out_valid_reg;
        trit_result_next   = trit_result_reg;
        binary_result_next = binary_result_reg;
        overflow_next      = overflow_reg;
        invalid_next       = invalid_reg;
        op_next            = op_reg;
        sh_next            = sh_reg;
        neg_next           = neg_reg;
        a_next             = a_reg;
        b_next             = b_reg;
        res_next           = res_reg;
        bad_next           = bad_reg;
        st_next            = st_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next       = req.opcode;
                    sh_next       = req.shift_amount;
                    neg_next      = req.binary_value[bta_pkg::WORD_W-1];
                    a_next        = req.operand_a;
                    b_next        = req.operand_b;
                    res_next      = '0;
                    bad_next      = bad_in;
                    st_next.carry = 2'sd0;
                    st_next.acc   = '0;
                    st_next.pow   = bta_pkg::POW_W'(1);
                    st_next.u     = req.binary_value[bta_pkg::WORD_W-1] ?
                                    unsigned'(-req.binary_value) :
                                    unsigned'(req.binary_value);
                    step_next     = '0;
                    state_next    = (req.opcode == bta_pkg::OP_FROM_BIN) ? ST_MUL : ST_STEP;
                end
            end
            ST_MUL:
            begin
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                st_next = step_res.st;
                // New trits enter at the top of the word and move down into place.
                if (in_word)
                begin
                    res_next = {2'b00, res_reg[bta_pkg::WORD_W-1:2]};
                    res_next[TOP_LSB +: 2] = step_res.code;
                end
                // A shift holds its source until the shift distance is reached.
                if ((op_reg != bta_pkg::OP_SHIFT) || sh_active)
                begin
                    a_next = {2'b00, a_reg[bta_pkg::WORD_W-1:2]};
                end
                b_next = {2'b00, b_reg[bta_pkg::WORD_W-1:2]};
                if (last_step)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    step_next  = step_reg + STEP_W'(1);
                    state_next = (op_reg == bta_pkg::OP_FROM_BIN) ? ST_MUL : ST_STEP;
                end
            end
            ST_DONE:
            begin
                // Load the output register once it is free.
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next     = 1'b1;
                    trit_result_next   = res_reg;
                    binary_result_next = st_reg.acc;
                    overflow_next      = ovf_final;
                    invalid_next       = bad_reg;
                    state_next         = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer state and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            step_reg          <= '0;
            out_valid_reg     <= 1'b0;
            trit_result_reg   <= '0;
            binary_result_reg <= '0;
            overflow_reg      <= 1'b0;
            invalid_reg       <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            step_reg          <= step_next;
            out_valid_reg     <= out_valid_next;
            trit_result_reg   <= trit_result_next;
            binary_result_reg <= binary_result_next;
            overflow_reg      <= overflow_next;
            invalid_reg       <= invalid_next;
        end
    end

    // Operand and working registers.
    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        sh_reg  <= sh_next;
        neg_reg <= neg_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        res_reg <= res_next;
        bad_reg <= bad_next;
        st_reg  <= st_next;
    end

    // An accepted transaction keeps the input closed in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("input ready right after an accepted transaction");

    // Every multiply cycle is followed by the step that consumes its quotient.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |=> (state_reg == ST_STEP))
        else $error("quotient not consumed after multiply");

    // Ternary to binary never overflows, and no other operation returns a binary value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.binary_result != '0)) |-> !rsp.overflow)
        else $error("overflow flagged with a binary result");

    // A result can only be loaded from the finishing state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result loaded outside the finishing state");

endmodule
